// File: rtl/simm_socket_system_io_registers_macros.svh
// ----------------------------------------------------------------------------
// SIMM socket and system I/O registers: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIMM_SOCKET_SYSTEM_IO_REGISTERS_MACROS_SVH
`define SIMM_SOCKET_SYSTEM_IO_REGISTERS_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SSIOR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssior check failed");

// next-cycle implication
`define SSIOR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssior check failed");

`endif

// File: rtl/ssior_pkg.sv
// ----------------------------------------------------------------------------
// SIMM socket and system I/O registers: package
// Port codes, result and SIMM map types, and the socket fill decode.
// ----------------------------------------------------------------------------
package ssior_pkg;

	localparam int TABLE_SLOTS = 8;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int SOCKETS     = 6;
	localparam int PAIRS       = SOCKETS / 2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [15:0] PORT_ENDIAN   = 16'h0092;
	localparam logic [15:0] PORT_SIMM_BIG = 16'h0803;
	localparam logic [15:0] PORT_PRESENCE = 16'h0804;
	localparam logic [15:0] PORT_STATUS_C = 16'h080C;
	localparam logic [15:0] PORT_CONTROL  = 16'h081C;
	localparam logic [15:0] PORT_END_TBL  = 16'h0820;
	localparam logic [15:0] PORT_STATUS_A = 16'h0841;
	localparam logic [15:0] PORT_MAP_MODE = 16'h0850;
	localparam logic [15:0] PORT_STATUS_D = 16'h0852;

	localparam logic [7:0] VAL_STATUS_A = 8'h01;
	localparam logic [7:0] VAL_STATUS_C = 8'hC0;
	localparam logic [7:0] VAL_STATUS_D = 8'hFC;
	localparam logic [7:0] VAL_UNMAPPED = 8'hFF;

	localparam logic [11:0] MEM_RESET_MB = 12'd64;
	localparam logic [11:0] BIG_PAIR_MB  = 12'd64;
	localparam logic [11:0] SMALL_PAIR_MB = 12'd16;

	typedef struct packed {
		logic [SOCKETS-1:0] present;
		logic [SOCKETS-1:0] big;
	} simm_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              map_event;
		logic [4:0]        map_start;
		logic signed [5:0] map_size;
		logic              little_endian_mode;
		logic              io_map_mode;
		logic [7:0]        system_control;
	} result_t;

	function automatic simm_t simm_decode(input logic [11:0] mb);
		logic [11:0] left;
		logic        stop;
		simm_t       r;
		left = mb;
		stop = 1'b0;
		r    = '0;
		for (int p = 0; p < PAIRS; p++) begin
			if (!stop && left >= BIG_PAIR_MB) begin
				r.present[2*p +: 2] = 2'b11;
				r.big[2*p +: 2]     = 2'b11;
				left = left - BIG_PAIR_MB;
			end else if (!stop && left >= SMALL_PAIR_MB) begin
				r.present[2*p +: 2] = 2'b11;
				left = left - SMALL_PAIR_MB;
			end else begin
				stop = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/simm_socket_system_io_registers.sv
// Path: an input transfer is held in the input register, then in the result register,
//   and is offered from there; it waits in that register while m_tready is low.
// Throughput: one access per cycle if m_tready is high; the decode is one pass.
// Reset (arst_n low): mode bits, control byte, table index and the eight-entry end
//   table clear at once, I/O map bit sets, memory size returns to 64 MB.
// ----------------------------------------------------------------------------
// SIMM socket and system I/O registers: top level
// Stream handshake, input and result registers around the access decode.
// ----------------------------------------------------------------------------
`include "simm_socket_system_io_registers_macros.svh"

module simm_socket_system_io_registers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // port[15:0], write_data[23:16]
	input  logic [0:0]  s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_data[7:0], map_start[12:8], map_size[18:13],
	                               // little_endian_mode[19], io_map_mode[20],
	                               // system_control[28:21], zero[31:29]
	output logic [0:0]  m_tuser,   // map_event[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                valid_s1;
	logic                opcode_s1;
	logic [15:0]         port_s1;
	logic [7:0]          wdata_s1;
	logic                valid_s2;
	ssior_pkg::result_t  result_s2;
	ssior_pkg::result_t  result_d;
	ssior_pkg::simm_t    simm;
	logic                advance;
	logic                in_xfer;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	ssior_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.simm    (simm)
	);

	ssior_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.opcode     (opcode_s1),
		.port       (port_s1),
		.write_data (wdata_s1),
		.simm       (simm),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= s_tuser[0];
			port_s1   <= s_tdata[15:0];
			wdata_s1  <= s_tdata[23:16];
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.map_event;
	assign m_tdata  = {3'd0, result_s2.system_control, result_s2.io_map_mode,
		result_s2.little_endian_mode, result_s2.map_size, result_s2.map_start,
		result_s2.read_data};

	`SSIOR_ASSERT_NEXT(a_advance_fills_out, advance, m_tvalid)
	`SSIOR_ASSERT_NOW(a_empty_takes_input, !valid_s1, s_tready)
	`SSIOR_ASSERT_NOW(a_event_on_write_only, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'd0)
	`SSIOR_ASSERT_NOW(a_no_event_zero_map, m_tvalid && !m_tuser[0], m_tdata[18:8] == 11'd0)

endmodule

// File: rtl/ssior_apb_regs.sv
// ----------------------------------------------------------------------------
// SIMM socket and system I/O registers: configuration port
// Holds the installed memory size and decodes it into the socket map.
// ----------------------------------------------------------------------------
module ssior_apb_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output ssior_pkg::simm_t       simm
);

	logic [11:0] memory_mb_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_mb_q <= ssior_pkg::MEM_RESET_MB;
		end else if (wr_en) begin
			memory_mb_q <= pwdata[11:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {20'd0, memory_mb_q};
	assign simm   = ssior_pkg::simm_decode(memory_mb_q);

endmodule

// File: rtl/ssior_core.sv
// ----------------------------------------------------------------------------
// SIMM socket and system I/O registers: access decode
// Mode registers, end address table and read/write decode for one transfer.
// ----------------------------------------------------------------------------
module ssior_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   opcode,
	input  logic [15:0]            port,
	input  logic [7:0]             write_data,
	input  ssior_pkg::simm_t       simm,
	output ssior_pkg::result_t     result
);

	logic                          endian_q;
	logic [7:0]                    control_q;
	logic                          map_flag_q;
	logic [ssior_pkg::SLOT_W-1:0]  rd_ptr_q;
	logic [4:0]                    end_tbl_q [ssior_pkg::TABLE_SLOTS];

	logic                          is_wr;
	logic [ssior_pkg::SLOT_W-1:0]  sock;
	logic [ssior_pkg::SLOT_W-1:0]  prev_sock;
	logic [4:0]                    end_addr;
	logic [ssior_pkg::SLOT_W-1:0]  tbl_addr;
	logic [4:0]                    tbl_data;
	logic [4:0]                    start;
	logic                          event_ok;

	logic                          endian_d;
	logic [7:0]                    control_d;
	logic                          map_flag_d;
	logic [ssior_pkg::SLOT_W-1:0]  rd_ptr_d;
	logic [7:0]                    rd_data;

	assign is_wr     = (opcode == ssior_pkg::OP_WRITE);
	assign sock      = write_data[7:5];
	assign prev_sock = sock - 3'd1;
	assign end_addr  = write_data[4:0];
	assign tbl_addr  = is_wr ? prev_sock : rd_ptr_q;
	assign tbl_data  = end_tbl_q[tbl_addr];
	assign start     = (sock == 3'd1) ? 5'd0 : tbl_data;
	assign event_ok  = is_wr && (port == ssior_pkg::PORT_END_TBL) && (sock != 3'd0)
		&& (sock != 3'd7) && simm.present[prev_sock];

	always_comb begin
		endian_d   = endian_q;
		control_d  = control_q;
		map_flag_d = map_flag_q;
		rd_ptr_d   = rd_ptr_q;
		rd_data    = 8'd0;
		if (is_wr) begin
			case (port)
				ssior_pkg::PORT_ENDIAN:   endian_d   = write_data[1];
				ssior_pkg::PORT_CONTROL:  control_d  = write_data;
				ssior_pkg::PORT_MAP_MODE: map_flag_d = write_data[0];
				default: ;
			endcase
		end else begin
			case (port)
				ssior_pkg::PORT_SIMM_BIG: rd_data = {2'b00, simm.big};
				ssior_pkg::PORT_PRESENCE: begin
					rd_data  = {2'b11, ~simm.present};
					rd_ptr_d = '0;
				end
				ssior_pkg::PORT_END_TBL: begin
					rd_data  = {3'd0, tbl_data};
					rd_ptr_d = rd_ptr_q + 3'd1;
				end
				ssior_pkg::PORT_STATUS_A: rd_data = ssior_pkg::VAL_STATUS_A;
				ssior_pkg::PORT_STATUS_C: rd_data = ssior_pkg::VAL_STATUS_C;
				ssior_pkg::PORT_STATUS_D: rd_data = ssior_pkg::VAL_STATUS_D;
				ssior_pkg::PORT_MAP_MODE: rd_data = {7'd0, map_flag_q};
				ssior_pkg::PORT_CONTROL:  rd_data = control_q;
				default:                  rd_data = ssior_pkg::VAL_UNMAPPED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endian_q   <= 1'b0;
			control_q  <= 8'd0;
			map_flag_q <= 1'b1;
			rd_ptr_q   <= '0;
			for (int i = 0; i < ssior_pkg::TABLE_SLOTS; i++) begin
				end_tbl_q[i] <= 5'd0;
			end
		end else if (en) begin
			endian_q   <= endian_d;
			control_q  <= control_d;
			map_flag_q <= map_flag_d;
			rd_ptr_q   <= rd_ptr_d;
			if (is_wr && port == ssior_pkg::PORT_END_TBL) begin
				end_tbl_q[sock] <= end_addr;
			end
		end
	end

	always_comb begin
		result.read_data          = rd_data;
		result.map_event          = event_ok;
		result.map_start          = event_ok ? start : 5'd0;
		result.map_size           = event_ok ? ($signed({1'b0, end_addr}) - $signed({1'b0, start}))
			: 6'sd0;
		result.little_endian_mode = endian_d;
		result.io_map_mode        = map_flag_d;
		result.system_control     = control_d;
	end

endmodule
